>>> rtl/sas_pkg.sv
// Package for the sprite attribute scan block: defaults, codes and field widths.
`default_nettype none
package sas_pkg;

  localparam int unsigned NumSpritesDef   = 40;
  localparam int unsigned MaxPerLineDef   = 10;
  localparam int unsigned DisplayLinesDef = 144;

  localparam logic [15:0] BaseAddr       = 16'hFE00;
  localparam int unsigned BytesPerSprite = 4;
  localparam int unsigned SlotOutW       = 6;

  typedef enum logic [1:0] {
    KindRead  = 2'd0,
    KindWrite = 2'd1,
    KindScan  = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadAddr  = 2'd1,
    StatusBadLine  = 2'd2,
    StatusRsvd     = 2'd3
  } status_e;

endpackage
`default_nettype wire

>>> rtl/sprite_attribute_scan.sv
// Sprite attribute memory with bus byte access and per-line sprite selection.
// A read, write or rejected item passes through the StResp state, which puts its one
// result beat into the output register once that register is free; the next item can
// be accepted after that. A scan reads one sprite row of the attribute memory per
// cycle, since the memory has a single row port, and ends early once MAX_PER_LINE
// sprites are found; it then emits its beats (at least one) as the output register
// frees. Selected sprites are inserted into an X-sorted list as they are found,
// so results leave in ascending X order with table order kept among equal X. One item
// is in work at a time; the output register lets a new item be accepted while the
// last beat still waits. After reset every row reads as zero, tracked by one valid
// flag per sprite row.
`default_nettype none
module sprite_attribute_scan
  import sas_pkg::*;
#(
  parameter int unsigned NUM_SPRITES   = NumSpritesDef,
  parameter int unsigned MAX_PER_LINE  = MaxPerLineDef,
  parameter int unsigned DISPLAY_LINES = DisplayLinesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          kind_i,
  input  wire logic [15:0]         bus_address_i,
  input  wire logic [7:0]          write_data_i,
  input  wire logic [7:0]          scan_line_i,
  input  wire logic                tall_sprites_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               status_o,
  output logic [7:0]               read_data_o,
  output logic                     hit_o,
  output logic [SlotOutW-1:0]      sprite_slot_o,
  output logic [7:0]               sprite_y_o,
  output logic [7:0]               sprite_x_o,
  output logic [7:0]               sprite_tile_o,
  output logic [7:0]               sprite_attr_o,
  output logic                     last_o
);

  localparam int unsigned SlotW   = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
  localparam int unsigned CntW    = $clog2(NUM_SPRITES + 1);
  localparam int unsigned NW      = $clog2(MAX_PER_LINE + 1);
  localparam int unsigned AddrEnd = BaseAddr + BytesPerSprite * NUM_SPRITES;

  typedef enum logic [1:0] {
    StIdle,
    StResp,
    StScan,
    StEmit
  } state_e;

  state_e state_q;

  // attribute memory: one 32-bit row per sprite {attr, tile, x, y}
  logic [31:0]      mem_q [NUM_SPRITES];
  logic             row_vld_q [NUM_SPRITES];
  logic [31:0]      rdata_q;
  logic             rvld_q;
  logic             rd_en;
  logic [SlotW-1:0] raddr;
  logic             wr_en;

  // decode
  logic             accept;
  logic             addr_ok;
  logic [15:0]      addr_off;
  logic [SlotW-1:0] addr_row;
  logic [1:0]       addr_lane;
  logic             line_ok;

  // per-item registers
  logic [1:0]       lane_q;
  logic             resp_rd_q;
  status_e          resp_status_q;
  logic [8:0]       row_q;
  logic             tall_q;
  logic [CntW-1:0]  cnt_q;
  logic [SlotW-1:0] cur_slot_q;

  // sorted selection list
  logic [31:0]      list_word_q [MAX_PER_LINE];
  logic [SlotW-1:0] list_slot_q [MAX_PER_LINE];
  logic [NW-1:0]    n_q;
  logic [31:0]      ins_word [MAX_PER_LINE];
  logic [SlotW-1:0] ins_slot [MAX_PER_LINE];
  logic             le [MAX_PER_LINE];

  logic [31:0]      rword;
  logic [7:0]       rbyte;
  logic [8:0]       y_ext;
  logic             covered;
  logic             out_free;
  logic             out_load;
  logic             scan_done;

  // output registers
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [7:0]       read_data_q;
  logic             hit_q;
  logic [SlotOutW-1:0] slot_q;
  logic [31:0]      word_q;
  logic             last_q;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign addr_ok   = ({1'b0, bus_address_i} >= {1'b0, BaseAddr}) &&
                     ({1'b0, bus_address_i} < 17'(AddrEnd));
  assign addr_off  = bus_address_i - BaseAddr;
  assign addr_row  = addr_off[SlotW+1:2];
  assign addr_lane = addr_off[1:0];
  assign line_ok   = scan_line_i < 8'(DISPLAY_LINES);

  assign wr_en = accept && (kind_e'(kind_i) == KindWrite) && addr_ok;
  assign rd_en = (accept && ((kind_e'(kind_i) == KindRead && addr_ok) ||
                             (kind_e'(kind_i) == KindScan && line_ok))) ||
                 (state_q == StScan && cnt_q < CntW'(NUM_SPRITES));
  assign raddr = (state_q == StIdle) ?
                 ((kind_e'(kind_i) == KindScan) ? '0 : addr_row) : cnt_q[SlotW-1:0];

  // byte-lane write; a row never written before gets its other lanes zeroed
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int l = 0; l < 4; l++) begin
        if (2'(l) == addr_lane) begin
          mem_q[addr_row][l*8 +: 8] <= write_data_i;
        end else if (!row_vld_q[addr_row]) begin
          mem_q[addr_row][l*8 +: 8] <= 8'h00;
        end
      end
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SPRITES; i++) begin
        row_vld_q[i] <= 1'b0;
      end
      rvld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[addr_row] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= row_vld_q[raddr];
      end
    end
  end

  assign rword = rvld_q ? rdata_q : 32'h0;
  assign rbyte = rword[lane_q*8 +: 8];

  // Y-16 <= line <= Y-16+h-1, compared with line shifted up by 16
  assign y_ext   = {1'b0, rword[7:0]};
  assign covered = (row_q >= y_ext) && (row_q < y_ext + (tall_q ? 9'd16 : 9'd8));

  // stable insertion: new entry goes after every entry with x <= new x
  always_comb begin
    for (int i = 0; i < MAX_PER_LINE; i++) begin
      le[i] = (NW'(i) < n_q) && (list_word_q[i][15:8] <= rword[15:8]);
    end
    for (int i = 0; i < MAX_PER_LINE; i++) begin
      if (le[i]) begin
        ins_word[i] = list_word_q[i];
        ins_slot[i] = list_slot_q[i];
      end else if (i == 0) begin
        ins_word[i] = rword;
        ins_slot[i] = cur_slot_q;
      end else if (le[i-1]) begin
        ins_word[i] = rword;
        ins_slot[i] = cur_slot_q;
      end else begin
        ins_word[i] = list_word_q[i-1];
        ins_slot[i] = list_slot_q[i-1];
      end
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = out_free && ((state_q == StResp) || (state_q == StEmit));
  assign scan_done = (cur_slot_q == SlotW'(NUM_SPRITES - 1)) ||
                     (covered && (n_q == NW'(MAX_PER_LINE - 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      n_q           <= '0;
      cnt_q         <= '0;
      cur_slot_q    <= '0;
      resp_rd_q     <= 1'b0;
      resp_status_q <= StatusOk;
      lane_q        <= '0;
      row_q         <= '0;
      tall_q        <= 1'b0;
      status_q      <= '0;
      read_data_q   <= '0;
      hit_q         <= 1'b0;
      slot_q        <= '0;
      word_q        <= '0;
      last_q        <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            lane_q     <= addr_lane;
            row_q      <= {1'b0, scan_line_i} + 9'd16;
            tall_q     <= tall_sprites_i;
            cnt_q      <= CntW'(1);
            cur_slot_q <= '0;
            n_q        <= '0;
            unique case (kind_e'(kind_i)) inside
              KindRead, KindWrite: begin
                resp_status_q <= addr_ok ? StatusOk : StatusBadAddr;
                resp_rd_q     <= (kind_e'(kind_i) == KindRead) && addr_ok;
                state_q       <= StResp;
              end
              KindScan: begin
                resp_rd_q <= 1'b0;
                if (line_ok) begin
                  state_q <= StScan;
                end else begin
                  resp_status_q <= StatusBadLine;
                  state_q       <= StResp;
                end
              end
              default: begin
                resp_rd_q     <= 1'b0;
                resp_status_q <= StatusOk;
                state_q       <= StResp;
              end
            endcase
          end
        end
        StResp: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= resp_status_q;
            read_data_q <= resp_rd_q ? rbyte : 8'h00;
            hit_q       <= 1'b0;
            slot_q      <= '0;
            word_q      <= '0;
            last_q      <= 1'b1;
            state_q     <= StIdle;
          end
        end
        StScan: begin
          if (covered) begin
            for (int i = 0; i < MAX_PER_LINE; i++) begin
              list_word_q[i] <= ins_word[i];
              list_slot_q[i] <= ins_slot[i];
            end
            n_q <= n_q + NW'(1);
          end
          if (cnt_q < CntW'(NUM_SPRITES)) begin
            cur_slot_q <= cnt_q[SlotW-1:0];
            cnt_q      <= cnt_q + CntW'(1);
          end
          if (scan_done) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= StatusOk;
            read_data_q <= 8'h00;
            if (n_q == '0) begin
              // nothing on this line: one empty beat
              hit_q   <= 1'b0;
              slot_q  <= '0;
              word_q  <= '0;
              last_q  <= 1'b1;
              state_q <= StIdle;
            end else begin
              hit_q  <= 1'b1;
              slot_q <= SlotOutW'(list_slot_q[0]);
              word_q <= list_word_q[0];
              last_q <= (n_q == NW'(1));
              for (int i = 0; i < MAX_PER_LINE - 1; i++) begin
                list_word_q[i] <= list_word_q[i+1];
                list_slot_q[i] <= list_slot_q[i+1];
              end
              n_q <= n_q - NW'(1);
              if (n_q == NW'(1)) begin
                state_q <= StIdle;
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_data_o   = read_data_q;
  assign hit_o         = hit_q;
  assign sprite_slot_o = slot_q;
  assign sprite_y_o    = word_q[7:0];
  assign sprite_x_o    = word_q[15:8];
  assign sprite_tile_o = word_q[23:16];
  assign sprite_attr_o = word_q[31:24];
  assign last_o        = last_q;

endmodule
`default_nettype wire

>>> bench/tb_sprite_attribute_scan.sv
// Testbench for sprite_attribute_scan: bus byte access, line scans, self-checking.
module tb_sprite_attribute_scan;
  import sas_pkg::*;

  localparam int unsigned MemBytes    = BytesPerSprite * NumSpritesDef;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic       hit;
    logic [5:0] slot;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic [7:0] attr;
    logic       last;
  } beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [15:0] bus_address_i;
  logic [7:0]  write_data_i;
  logic [7:0]  scan_line_i;
  logic        tall_sprites_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  read_data_o;
  logic        hit_o;
  logic [5:0]  sprite_slot_o;
  logic [7:0]  sprite_y_o;
  logic [7:0]  sprite_x_o;
  logic [7:0]  sprite_tile_o;
  logic [7:0]  sprite_attr_o;
  logic        last_o;

  // shadow copy of the attribute memory, updated in order of acceptance
  logic [7:0] oam_shadow [MemBytes];
  beat_t      expected_beats [$];
  beat_t      got_beat;
  beat_t      want_beat;

  int unsigned feed_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned scans_sent    = 0;
  int unsigned beats_seen    = 0;
  int unsigned hits_seen     = 0;
  int unsigned stall_cycles  = 0;

  sprite_attribute_scan DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .bus_address_i  (bus_address_i),
    .write_data_i   (write_data_i),
    .scan_line_i    (scan_line_i),
    .tall_sprites_i (tall_sprites_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .read_data_o    (read_data_o),
    .hit_o          (hit_o),
    .sprite_slot_o  (sprite_slot_o),
    .sprite_y_o     (sprite_y_o),
    .sprite_x_o     (sprite_x_o),
    .sprite_tile_o  (sprite_tile_o),
    .sprite_attr_o  (sprite_attr_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void queue_beat(beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic beat_t sprite_beat(int slot, logic last);
    beat_t b;
    b        = '0;
    b.status = StatusOk;
    b.hit    = 1'b1;
    b.slot   = 6'(slot);
    b.y      = oam_shadow[slot*BytesPerSprite];
    b.x      = oam_shadow[slot*BytesPerSprite+1];
    b.tile   = oam_shadow[slot*BytesPerSprite+2];
    b.attr   = oam_shadow[slot*BytesPerSprite+3];
    b.last   = last;
    return b;
  endfunction

  // Works out the beats one item yields and queues them; applies writes to the shadow.
  function automatic void predict_beats(kind_e kind, logic [15:0] addr, logic [7:0] data,
                                        logic [7:0] line, logic tall);
    beat_t b;
    int    sorted_slots [$];
    int    height;
    int    row;
    int    ybyte;
    int    pos;
    logic [7:0] xbyte;
    b        = '0;
    b.status = StatusOk;
    b.last   = 1'b1;
    case (kind) inside
      KindRead, KindWrite: begin
        if (addr < BaseAddr || addr >= BaseAddr + MemBytes) begin
          b.status = StatusBadAddr;
        end else if (kind == KindRead) begin
          b.read_data = oam_shadow[addr - BaseAddr];
        end else begin
          oam_shadow[addr - BaseAddr] = data;
        end
        queue_beat(b);
      end
      KindScan: begin
        if (line >= DisplayLinesDef) begin
          b.status = StatusBadLine;
          queue_beat(b);
        end else begin
          height = tall ? 16 : 8;
          row    = int'(line) + 16;
          for (int s = 0; s < NumSpritesDef && sorted_slots.size() < MaxPerLineDef; s++) begin
            ybyte = oam_shadow[s*BytesPerSprite];
            if (row >= ybyte && row < ybyte + height) begin
              // insert after every entry with X not above ours: keeps table order on ties
              xbyte = oam_shadow[s*BytesPerSprite+1];
              pos   = sorted_slots.size();
              for (int k = 0; k < sorted_slots.size(); k++) begin
                if (oam_shadow[sorted_slots[k]*BytesPerSprite+1] > xbyte) begin
                  pos = k;
                  break;
                end
              end
              sorted_slots.insert(pos, s);
            end
          end
          if (sorted_slots.size() == 0) begin
            queue_beat(b);
          end else begin
            foreach (sorted_slots[i]) begin
              queue_beat(sprite_beat(sorted_slots[i], i == sorted_slots.size() - 1));
            end
          end
        end
      end
      default: queue_beat(b);
    endcase
  endfunction

  task automatic send_item(kind_e kind, logic [15:0] addr, logic [7:0] data,
                           logic [7:0] line, logic tall);
    @(negedge clk_i);
    while ($urandom_range(99) < feed_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    kind_i         = kind;
    bus_address_i  = addr;
    write_data_i   = data;
    scan_line_i    = line;
    tall_sprites_i = tall;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beats(kind, addr, data, line, tall);
    items_sent++;
    if (kind == KindScan) scans_sent++;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic string beat_text(beat_t b);
    return $sformatf("st=%0d rd=%02h hit=%0d slot=%0d y=%02h x=%02h tile=%02h attr=%02h last=%0d",
                     b.status, b.read_data, b.hit, b.slot, b.y, b.x, b.tile, b.attr, b.last);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_beat = '{status_o, read_data_o, hit_o, sprite_slot_o, sprite_y_o, sprite_x_o,
                   sprite_tile_o, sprite_attr_o, last_o};
      beats_seen++;
      if (got_beat.hit) hits_seen++;
      if (expected_beats.size() == 0) begin
        if (mismatches < 10) $display("%0t: unexpected beat: %s", $time, beat_text(got_beat));
        mismatches++;
      end else begin
        want_beat = expected_beats.pop_front();
        if (got_beat !== want_beat) begin
          if (mismatches < 10) begin
            $display("%0t: beat mismatch", $time);
            $display("  expected %s", beat_text(want_beat));
            $display("  actual   %s", beat_text(got_beat));
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_bus_access();
    send_item(KindWrite, BaseAddr, 8'hFF, 8'h00, 1'b0);
    send_item(KindRead, BaseAddr, 8'h00, 8'h00, 1'b0);
    send_item(KindWrite, 16'hFE9F, 8'hA5, 8'h00, 1'b0);
    send_item(KindRead, 16'hFE9F, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_bad_address();
    send_item(KindWrite, 16'hFDFF, 8'h5A, 8'h00, 1'b0);
    send_item(KindRead, 16'hFEA0, 8'h00, 8'h00, 1'b0);
    send_item(KindRead, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
  endtask

  task automatic test_bad_line();
    send_item(KindScan, 16'h0000, 8'h00, 8'd144, 1'b0);
    send_item(KindScan, 16'hFFFF, 8'hFF, 8'd255, 1'b1);
  endtask

  task automatic test_unused_kind();
    send_item(KindNone, 16'hFE04, 8'h77, 8'd10, 1'b1);
  endtask

  task automatic test_empty_scan();
    send_item(KindScan, 16'h0000, 8'h00, 8'd0, 1'b0);
    send_item(KindScan, 16'h0000, 8'h00, 8'd143, 1'b1);
  endtask

  // eleven sprites on one line: the last in table order is dropped, slot 1 sorts last
  task automatic test_overflow_and_order();
    for (int i = 0; i < 11; i++) begin
      send_item(KindWrite, BaseAddr + 16'((2*i + 1) * BytesPerSprite), 8'd116, 8'h00, 1'b0);
    end
    send_item(KindWrite, BaseAddr + 16'(BytesPerSprite + 1), 8'h80, 8'h00, 1'b0);
    send_item(KindWrite, BaseAddr + 16'(3*BytesPerSprite + 3), 8'hF0, 8'h00, 1'b0);
    send_item(KindScan, 16'h0000, 8'h00, 8'd100, 1'b0);
  endtask

  // Mostly sprite setup plus scans near a moving hot line, with some noise.
  task automatic test_random_traffic(int n_items, int unsigned feed_pct, int unsigned sink_pct);
    int unsigned roll;
    int          done;
    int          hot_line;
    int          slot;
    int          byte_sel;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  line;
    kind_e       kind;
    feed_idle_pct = feed_pct;
    sink_idle_pct = sink_pct;
    done          = 0;
    hot_line      = $urandom_range(143);
    while (done < n_items) begin
      if ($urandom_range(19) == 0) hot_line = $urandom_range(143);
      roll     = $urandom_range(99);
      slot     = $urandom_range(NumSpritesDef - 1);
      byte_sel = $urandom_range(BytesPerSprite - 1);
      addr     = BaseAddr + 16'(slot * BytesPerSprite + byte_sel);
      data     = 8'($urandom_range(255));
      line     = 8'($urandom_range(255));
      if (roll < 40) begin
        if (byte_sel == 0 && $urandom_range(9) < 7) begin
          data = 8'(hot_line + 16 - $urandom_range(15));
        end else if (byte_sel == 1 && $urandom_range(1) == 0) begin
          data = 8'($urandom_range(7));
        end
        send_item(KindWrite, addr, data, line, 1'($urandom_range(1)));
      end else if (roll < 55) begin
        send_item(KindRead, addr, data, line, 1'($urandom_range(1)));
      end else if (roll < 88) begin
        line = ($urandom_range(9) < 6) ? 8'(hot_line) : 8'($urandom_range(143));
        send_item(KindScan, addr, data, line, 1'($urandom_range(1)));
      end else if (roll < 93) begin
        send_item(KindScan, addr, data, 8'($urandom_range(255, 144)),
                  1'($urandom_range(1)));
      end else if (roll < 97) begin
        addr = 16'($urandom_range(65535));
        if (addr >= BaseAddr && addr < BaseAddr + MemBytes) addr = addr ^ 16'h8000;
        kind = $urandom_range(1) ? KindWrite : KindRead;
        send_item(kind, addr, data, line, 1'($urandom_range(1)));
      end else begin
        send_item(KindNone, 16'($urandom_range(65535)), data, line, 1'($urandom_range(1)));
        done--;
      end
      done++;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KindRead;
    bus_address_i  = '0;
    write_data_i   = '0;
    scan_line_i    = '0;
    tall_sprites_i = 1'b0;
    for (int i = 0; i < MemBytes; i++) oam_shadow[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_bus_access();
    test_bad_address();
    test_bad_line();
    test_unused_kind();
    test_empty_scan();
    test_overflow_and_order();
    test_random_traffic(25, 22, 64);
    test_random_traffic(25, 64, 22);
    test_random_traffic(25, 0, 0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items (%0d scans); checked %0d result beats, %0d carrying sprites.",
             items_sent, scans_sent, beats_seen, hits_seen);
    $display("Idle mixes: sender-heavy, receiver-heavy and none; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sas_pkg.sv
rtl/sprite_attribute_scan.sv
bench/tb_sprite_attribute_scan.sv
